FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the same cycle whenever cond holds.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that prop holds in the cycle after cond holds.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/sro_pkg.sv
// ----------------------------------------------------------------------------
// sro_pkg
// Types, widths and codes for the slalom route offset block.
// ----------------------------------------------------------------------------
package sro_pkg;

    // Coordinate format: signed Q8.16
    localparam int COORD_BITS = 24;

    // Datapath widths
    localparam int DIFF_W   = COORD_BITS + 1;        // point difference magnitude, root
    localparam int SQ_W     = 2 * DIFF_W;            // sum of squares, products
    localparam int QUO_W    = COORD_BITS;            // offset quotient
    localparam int REM_W    = DIFF_W + 3;            // partial remainder
    localparam int SUM_W    = COORD_BITS + 2;        // offset sum before saturation
    localparam int CNT_W    = $clog2(DIFF_W);        // step counter

    // Configuration register widths
    localparam int BYPASS_W  = 23;
    localparam int MINLEN_W  = 17;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SIDE = 2'd2;

    // Configuration reset values
    localparam logic [BYPASS_W-1:0] BYPASS_RESET  = 23'd22938;
    localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = 17'd66;

    // Point kinds
    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_OBSTACLE = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t     point_x;
        coord_t     point_y;
        logic [1:0] point_kind;
    } point_in_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   route_last;
    } point_out_t;

    // Clamp a widened sum to the coordinate range
    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        coord_t r;
        if (v[SUM_W-1:COORD_BITS-1] == '0 || v[SUM_W-1:COORD_BITS-1] == '1)
        begin
            r = v[COORD_BITS-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: src/slalom_route_offset_top.sv
// ----------------------------------------------------------------------------
// slalom_route_offset_top
// Slalom route generator: offsets obstacle points sideways along the normal.
// ----------------------------------------------------------------------------
// Points enter one at a time: a start point, any number of obstacles, then an
// end point. A start point, or an end point with no obstacle waiting, passes
// through the S_ECHO state into the output register, and the next point is
// taken once the block is back in S_IDLE. An obstacle with none waiting is
// stored in its transfer cycle, and the next point may follow at once. An
// obstacle or end point that releases a waiting obstacle offers the offset
// point from the S_OFS state; an end point then passes through S_ECHO, so its
// own echo follows the offset point. One shared subtractor runs a 25-step
// square root of the squared direction length, then two 24-step divisions for
// the x and y offsets, and one shared 25 x 25 multiplier forms the squares and
// products. The point input stalls for the whole of that work. A finished
// result sits in an output register, and the next point is taken while it
// waits; while a full output register is stalled, S_OFS and S_ECHO wait,
// which delays the next result.

`include "assert_macros.svh"

module slalom_route_offset_top
    import sro_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // point input channel
    input  logic                 point_valid,
    output logic                 point_stall,
    input  point_in_t            point,
    // route output channel
    output logic                 route_valid,
    input  logic                 route_stall,
    output point_out_t           route,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQRT,
        S_CLAMP,
        S_MULX,
        S_NUMX,
        S_DIVX,
        S_MULY,
        S_NUMY,
        S_DIVY,
        S_OFS,
        S_ECHO
    } state_t;

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    cnt_reg,        cnt_next;
    point_in_t           item_reg,       item_next;
    coord_t              prev_x_reg,     prev_x_next;
    coord_t              prev_y_reg,     prev_y_next;
    coord_t              pend_x_reg,     pend_x_next;
    coord_t              pend_y_reg,     pend_y_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                side_reg,       side_next;
    logic [DIFF_W-1:0]   ax_reg,         ax_next;
    logic [DIFF_W-1:0]   ay_reg,         ay_next;
    logic                neg_x_reg,      neg_x_next;
    logic                neg_y_reg,      neg_y_next;
    logic [SQ_W-1:0]     prod_reg,       prod_next;
    logic [SQ_W-1:0]     src_reg,        src_next;
    logic [REM_W-1:0]    rem_reg,        rem_next;
    logic [DIFF_W-1:0]   acc_reg,        acc_next;
    logic [DIFF_W-1:0]   len_reg,        len_next;
    logic [QUO_W-1:0]    qx_reg,         qx_next;
    logic                route_valid_reg, route_valid_next;
    point_out_t          route_reg,      route_next;
    logic [BYPASS_W-1:0] bypass_reg,     bypass_next;
    logic [MINLEN_W-1:0] min_len_reg,    min_len_next;
    logic                first_neg_reg,  first_neg_next;

    logic                    point_xfer;
    logic                    route_free;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]       mul_a;
    logic [DIFF_W-1:0]       mul_b;
    logic [SQ_W-1:0]         mul_p;
    logic [REM_W-1:0]        sub_a;
    logic [REM_W-1:0]        sub_b;
    logic [REM_W:0]          sub_diff;
    logic                    sub_ok;
    logic [REM_W-1:0]        step_rem;
    logic [DIFF_W-1:0]       step_acc;
    logic [SQ_W-1:0]         num;
    logic [DIFF_W-1:0]       floor_len;
    logic                    neg_tx;
    logic                    neg_ty;
    logic signed [SUM_W-1:0] term_x;
    logic signed [SUM_W-1:0] term_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    // Handshake
    assign point_stall = (state_reg != S_IDLE);
    assign point_xfer  = point_valid && !point_stall;
    assign route_free  = !route_valid_reg || !route_stall;
    assign route_valid = route_valid_reg;
    assign route       = route_reg;

    // Direction from the previous point to the new one
    assign dx = DIFF_W'(point.point_x) - DIFF_W'(prev_x_reg);
    assign dy = DIFF_W'(point.point_y) - DIFF_W'(prev_y_reg);

    // Shared multiplier: squares, then bypass distance times each magnitude
    always_comb
    begin
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_MULX:
            begin
                mul_a = DIFF_W'(bypass_reg);
                mul_b = ax_reg;
            end
            default:
            begin
                mul_a = DIFF_W'(bypass_reg);
                mul_b = ay_reg;
            end
        endcase
    end

    assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);

    // Shared trial subtractor: root digit or quotient bit
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            sub_a = {rem_reg[REM_W-3:0], src_reg[SQ_W-1 -: 2]};
            sub_b = REM_W'({acc_reg, 2'b01});
        end
        else
        begin
            sub_a = {rem_reg[REM_W-2:0], src_reg[SQ_W-1]};
            sub_b = REM_W'(len_reg);
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok   = !sub_diff[REM_W];
    assign step_rem = sub_ok ? sub_diff[REM_W-1:0] : sub_a;
    assign step_acc = {acc_reg[DIFF_W-2:0], sub_ok};

    // Rounded dividend and length floor
    assign num       = prod_reg + SQ_W'(len_reg >> 1);
    assign floor_len = (min_len_reg == '0) ? DIFF_W'(1) : DIFF_W'(min_len_reg);

    // Offset terms: qy comes from the accumulator, qx from its holding register
    assign neg_tx = neg_y_reg ^ ~side_reg;
    assign neg_ty = neg_x_reg ^ side_reg;
    assign term_x = neg_tx ? -SUM_W'(acc_reg[QUO_W-1:0]) : SUM_W'(acc_reg[QUO_W-1:0]);
    assign term_y = neg_ty ? -SUM_W'(qx_reg) : SUM_W'(qx_reg);
    assign sum_x  = SUM_W'(pend_x_reg) + term_x;
    assign sum_y  = SUM_W'(pend_y_reg) + term_y;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        item_next        = item_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_valid_next  = pend_valid_reg;
        side_next        = side_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        prod_next        = prod_reg;
        src_next         = src_reg;
        rem_next         = rem_reg;
        acc_next         = acc_reg;
        len_next         = len_reg;
        qx_next          = qx_reg;
        route_next       = route_reg;
        bypass_next      = bypass_reg;
        min_len_next     = min_len_reg;
        first_neg_next   = first_neg_reg;

        // drop the output once it has been transferred
        route_valid_next = route_valid_reg && route_stall;

        // configuration writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BYPASS:     bypass_next    = cfg_wdata[BYPASS_W-1:0];
                CFG_MIN_LEN:    min_len_next   = cfg_wdata[MINLEN_W-1:0];
                CFG_FIRST_SIDE: first_neg_next = cfg_wdata[0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_xfer)
                begin
                    item_next  = point;
                    ax_next    = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                    ay_next    = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                    neg_x_next = dx[DIFF_W-1];
                    neg_y_next = dy[DIFF_W-1];
                    unique case (point.point_kind)
                        KIND_START:
                        begin
                            state_next = S_ECHO;
                        end
                        KIND_OBSTACLE:
                        begin
                            if (pend_valid_reg)
                            begin
                                state_next = S_SQX;
                            end
                            else
                            begin
                                pend_x_next     = point.point_x;
                                pend_y_next     = point.point_y;
                                pend_valid_next = 1'b1;
                            end
                        end
                        KIND_END:
                        begin
                            state_next = pend_valid_reg ? S_SQX : S_ECHO;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // squared length through the multiplier
            S_SQX:
            begin
                prod_next  = mul_p;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                src_next   = prod_reg;
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                src_next   = src_reg + prod_reg;
                rem_next   = '0;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end

            // root, two bits of the radicand per step
            S_SQRT:
            begin
                rem_next = step_rem;
                acc_next = step_acc;
                src_next = src_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIFF_W - 1))
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                len_next   = (acc_reg < floor_len) ? floor_len : acc_reg;
                state_next = S_MULX;
            end

            // x and y offsets: product, rounded dividend, division
            S_MULX:
            begin
                prod_next  = mul_p;
                state_next = S_NUMX;
            end
            S_MULY:
            begin
                prod_next  = mul_p;
                state_next = S_NUMY;
            end
            S_NUMX, S_NUMY:
            begin
                src_next   = {num[QUO_W-1:0], {(SQ_W-QUO_W){1'b0}}};
                rem_next   = REM_W'(num[SQ_W-1:QUO_W]);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = (state_reg == S_NUMX) ? S_DIVX : S_DIVY;
            end
            S_DIVX, S_DIVY:
            begin
                rem_next = step_rem;
                acc_next = step_acc;
                src_next = src_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    if (state_reg == S_DIVX)
                    begin
                        qx_next    = step_acc[QUO_W-1:0];
                        state_next = S_MULY;
                    end
                    else
                    begin
                        state_next = S_OFS;
                    end
                end
            end

            // emit the offset obstacle, then advance the route state
            S_OFS:
            begin
                if (route_free)
                begin
                    route_valid_next      = 1'b1;
                    route_next.out_x      = sat_coord(sum_x);
                    route_next.out_y      = sat_coord(sum_y);
                    route_next.route_last = 1'b0;
                    side_next             = ~side_reg;
                    if (item_reg.point_kind == KIND_OBSTACLE)
                    begin
                        prev_x_next = pend_x_reg;
                        prev_y_next = pend_y_reg;
                        pend_x_next = item_reg.point_x;
                        pend_y_next = item_reg.point_y;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ECHO;
                    end
                end
            end

            // echo a start or end point
            S_ECHO:
            begin
                if (route_free)
                begin
                    route_valid_next      = 1'b1;
                    route_next.out_x      = item_reg.point_x;
                    route_next.out_y      = item_reg.point_y;
                    route_next.route_last = (item_reg.point_kind == KIND_END);
                    prev_x_next           = item_reg.point_x;
                    prev_y_next           = item_reg.point_y;
                    pend_valid_next       = 1'b0;
                    if (item_reg.point_kind == KIND_START)
                    begin
                        side_next = first_neg_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            item_reg        <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            side_reg        <= 1'b0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            prod_reg        <= '0;
            src_reg         <= '0;
            rem_reg         <= '0;
            acc_reg         <= '0;
            len_reg         <= '0;
            qx_reg          <= '0;
            route_valid_reg <= 1'b0;
            route_reg       <= '0;
            bypass_reg      <= BYPASS_RESET;
            min_len_reg     <= MIN_LEN_RESET;
            first_neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            item_reg        <= item_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            pend_x_reg      <= pend_x_next;
            pend_y_reg      <= pend_y_next;
            pend_valid_reg  <= pend_valid_next;
            side_reg        <= side_next;
            ax_reg          <= ax_next;
            ay_reg          <= ay_next;
            neg_x_reg       <= neg_x_next;
            neg_y_reg       <= neg_y_next;
            prod_reg        <= prod_next;
            src_reg         <= src_next;
            rem_reg         <= rem_next;
            acc_reg         <= acc_next;
            len_reg         <= len_next;
            qx_reg          <= qx_next;
            route_valid_reg <= route_valid_next;
            route_reg       <= route_next;
            bypass_reg      <= bypass_next;
            min_len_reg     <= min_len_next;
            first_neg_reg   <= first_neg_next;
        end
    end

    // Root remainder never exceeds twice the partial root plus one
    `ASSERT_IMPLY(a_sqrt_rem_bound, state_reg == S_SQRT, (rem_reg >> 1) <= REM_W'(acc_reg), "root remainder out of bound")
    // Division remainder stays below the divisor
    `ASSERT_IMPLY(a_div_rem_bound, state_reg == S_DIVX || state_reg == S_DIVY, rem_reg < REM_W'(len_reg), "division remainder not below length")
    // Clamped length is never zero
    `ASSERT_IMPLY(a_len_nonzero, state_reg == S_MULX, len_reg != '0, "zero divisor after clamp")
    // An offset obstacle leaves the output register unmarked as last
    `ASSERT_NEXT(a_ofs_not_last, state_reg == S_OFS && route_free, route_valid_reg && !route_reg.route_last, "offset point marked last")

endmodule
